[rtl/ata_pkg.sv]
`default_nettype none
package ata_pkg;

    // Number of CORDIC iterations that the table covers.
    localparam int unsigned TableLen = 24;
    localparam int unsigned CordicSteps = 16;

    // Saturation limit of the Q7.8 angle, in LSBs (90 degrees).
    localparam logic signed [31:0] AngleLimit = 32'sd23040;

    // Widths of the datapath.
    localparam int unsigned SqW = 33;   // sum of two squares
    localparam int unsigned RadW = 66;  // radicand after shifting by 32
    localparam int unsigned MagW = 33;  // square root of the radicand
    localparam int unsigned VecW = 36;  // CORDIC x and y
    localparam int unsigned AngW = 32;  // angle in degrees, Q.16

    // Shift and add square root: one result bit per cell.
    localparam int unsigned SqrtCells = 33;

    // Payload that travels along the square-root cells.
    typedef struct packed {
        logic [RadW-1:0] rem;
        logic [MagW-1:0] root;
    } t_sqrt_lane;

    // Payload that travels along the CORDIC cells.
    typedef struct packed {
        logic signed [VecW-1:0] xv;
        logic signed [VecW-1:0] yv;
        logic signed [AngW-1:0] ang;
        logic                   zero;
    } t_cordic_lane;

    // atan(2^-i) in degrees, Q.16, rounded to nearest.
    function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] idx);
        logic signed [AngW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117305;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/accel_tilt_angles.sv]
// Tilt angles from a raw accelerometer triple.
// Slave channel: one request per cycle, unless stalled, carries accel_x, accel_y, accel_z.
// Master channel: x_rotation and y_rotation in signed Q7.8 degrees.
// Each request passes through a squaring stage, a radicand stage, 33
// square-root cells (one result bit each), CORDIC_STEPS CORDIC cells (at most
// 24 steps) and a rounding stage.
// Throughput is one request per cycle while the pipeline is not stalled; both angles run in parallel chains.
// The whole pipeline advances when the output register is empty or being
// taken, so a stalled receiver freezes every stage and s_axis_tready drops;
// nothing is lost. A valid bit travels with each stage.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none
module accel_tilt_angles #(
    parameter int unsigned CORDIC_STEPS = ata_pkg::CordicSteps
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // x_rotation [15:0], y_rotation [31:16]
    output logic [31:0]      m_axis_tdata
);

    localparam int unsigned Steps = (CORDIC_STEPS > ata_pkg::TableLen) ?
        ata_pkg::TableLen : CORDIC_STEPS;
    localparam int unsigned Depth = Steps + 36;

    logic              w_en;
    logic [Depth-1:0]  r_vld;
    logic signed [15:0] w_ax, w_ay, w_az, w_xr, w_yr;

    assign w_ax = s_axis_tdata[15:0];
    assign w_ay = s_axis_tdata[31:16];
    assign w_az = s_axis_tdata[47:32];

    // The pipeline moves when its last stage is free or drained.
    assign w_en = !r_vld[Depth-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
        end
    end

    ata_tilt_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_xrot (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_ay),
        .i_p      (w_ax),
        .i_q      (w_az),
        .i_negate (1'b0),
        .o_angle  (w_xr)
    );

    ata_tilt_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_yrot (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_ax),
        .i_p      (w_ay),
        .i_q      (w_az),
        .i_negate (1'b1),
        .o_angle  (w_yr)
    );

    assign m_axis_tvalid = r_vld[Depth-1];
    assign m_axis_tdata  = {w_yr, w_xr};

endmodule
`default_nettype wire

[rtl/ata_sqrt_cell.sv]
`default_nettype none
// One bit of a restoring square root: tries the bit at weight 4^(BitIdx).
module ata_sqrt_cell #(
    parameter int unsigned BitIdx = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire ata_pkg::t_sqrt_lane   i_lane,
    output ata_pkg::t_sqrt_lane        o_lane
);

    localparam int unsigned RadW = ata_pkg::RadW;

    ata_pkg::t_sqrt_lane r_lane;
    ata_pkg::t_sqrt_lane n_lane;
    logic [RadW-1:0]     w_trial;
    logic [RadW-1:0]     w_root_ext;

    // The root holds the bits decided so far, so the trial is
    // (root << (2*BitIdx+2)) + 4^BitIdx.
    always_comb begin
        w_root_ext = RadW'(i_lane.root);
        w_trial = (w_root_ext << (2 * BitIdx + 2)) | (RadW'(1) << (2 * BitIdx));
        n_lane = i_lane;
        n_lane.root = i_lane.root << 1;
        if (i_lane.rem >= w_trial) begin
            n_lane.rem = i_lane.rem - w_trial;
            n_lane.root[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

[rtl/ata_cordic_cell.sv]
`default_nettype none
// One vectoring CORDIC iteration at shift Step.
module ata_cordic_cell #(
    parameter int unsigned Step = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire ata_pkg::t_cordic_lane i_lane,
    output ata_pkg::t_cordic_lane      o_lane
);

    localparam logic [4:0] StepIdx = 5'(Step);

    ata_pkg::t_cordic_lane r_lane;
    ata_pkg::t_cordic_lane n_lane;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        n_lane = i_lane;
        if (i_lane.yv > 0) begin
            n_lane.xv  = i_lane.xv + (i_lane.yv >>> Step);
            n_lane.yv  = i_lane.yv - (i_lane.xv >>> Step);
            n_lane.ang = i_lane.ang + ata_pkg::atan_deg(StepIdx);
        end else begin
            n_lane.xv  = i_lane.xv - (i_lane.yv >>> Step);
            n_lane.yv  = i_lane.yv + (i_lane.xv >>> Step);
            n_lane.ang = i_lane.ang - ata_pkg::atan_deg(StepIdx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

[rtl/ata_tilt_chain.sv]
`default_nettype none
// One tilt angle: squares, a chain of square-root cells, a chain of CORDIC
// cells and rounding. Every stage moves when i_en is high.
module ata_tilt_chain #(
    parameter int unsigned CORDIC_STEPS = ata_pkg::CordicSteps
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_num,
    input  wire logic signed [15:0] i_p,
    input  wire logic signed [15:0] i_q,
    input  wire logic               i_negate,
    output logic signed [15:0]      o_angle
);

    localparam int unsigned Steps = (CORDIC_STEPS > ata_pkg::TableLen) ?
        ata_pkg::TableLen : CORDIC_STEPS;
    localparam int unsigned Cells = ata_pkg::SqrtCells;
    localparam int unsigned RadW  = ata_pkg::RadW;
    localparam int unsigned VecW  = ata_pkg::VecW;
    localparam int unsigned AngW  = ata_pkg::AngW;

    // Stage 0: squares, registered.
    logic [31:0]        r_pp;
    logic [31:0]        r_qq;
    logic signed [15:0] r_num0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp   <= 32'(32'(i_p) * 32'(i_p));
            r_qq   <= 32'(32'(i_q) * 32'(i_q));
            r_num0 <= i_num;
        end
    end

    // The numerator rides alongside the square-root cells.
    logic signed [15:0] r_num_dly [Cells+1];
    ata_pkg::t_sqrt_lane r_rad;
    ata_pkg::t_sqrt_lane w_sq [Cells+1];
    logic [ata_pkg::SqW-1:0] w_sum;

    assign w_sum = {1'b0, r_pp} + {1'b0, r_qq};

    // Stage 1: form the radicand, and delay the numerator in step.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad.rem    <= RadW'(w_sum) << 32;
            r_rad.root   <= '0;
            r_num_dly[0] <= r_num0;
            for (int k = 0; k < Cells; k++) begin
                r_num_dly[k+1] <= r_num_dly[k];
            end
        end
    end

    assign w_sq[0] = r_rad;

    for (genvar g = 0; g < Cells; g++) begin : g_sqrt
        ata_sqrt_cell #(.BitIdx(Cells - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_lane (w_sq[g]),
            .o_lane (w_sq[g+1])
        );
    end

    // CORDIC entry, with the zero-vector flag.
    ata_pkg::t_cordic_lane w_cl_in;
    ata_pkg::t_cordic_lane w_cl [Steps+1];
    always_comb begin
        w_cl_in.xv   = VecW'(signed'({1'b0, w_sq[Cells].root}));
        w_cl_in.yv   = VecW'(r_num_dly[Cells]) <<< 16;
        w_cl_in.ang  = '0;
        w_cl_in.zero = (w_sq[Cells].root == '0) && (r_num_dly[Cells] == '0);
    end

    assign w_cl[0] = w_cl_in;

    for (genvar s = 0; s < Steps; s++) begin : g_cordic
        ata_cordic_cell #(.Step(s)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_lane (w_cl[s]),
            .o_lane (w_cl[s+1])
        );
    end

    // Negate, round half up and saturate to Q7.8.
    logic signed [AngW:0] w_ang;
    logic signed [AngW:0] w_rnd;
    logic signed [15:0]   r_angle;

    always_comb begin
        w_ang = w_cl[Steps].zero ? '0 : (AngW+1)'(w_cl[Steps].ang);
        if (i_negate) begin
            w_ang = -w_ang;
        end
        w_rnd = (w_ang + (AngW+1)'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_rnd > (AngW+1)'(ata_pkg::AngleLimit)) begin
                r_angle <= 16'(ata_pkg::AngleLimit);
            end else if (w_rnd < -(AngW+1)'(ata_pkg::AngleLimit)) begin
                r_angle <= -16'(ata_pkg::AngleLimit);
            end else begin
                r_angle <= 16'(w_rnd);
            end
        end
    end

    assign o_angle = r_angle;

endmodule
`default_nettype wire
